### design/rle_pkg.sv
// shared constants and types for the run-length encoder with count marker
// no dependencies; used by the front, queue, back and top-level files
`default_nettype none

package rle_pkg;

  // largest number of extra repeats held in one run
  localparam int unsigned MAX_EXTRA = 9;

  // count of extra repeats from which the marker form is used
  localparam logic [3:0] MARKER_MIN = 4'd2;

  localparam logic [7:0] MARKER_BYTE = 8'h24;
  localparam logic [7:0] DIGIT_ZERO  = 8'h30;

  // run queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // one finished run waiting to be expanded
  typedef struct packed {
    logic [7:0] run_byte;
    logic [3:0] extra;
    logic       last;
  } run_cmd_t;

  // what the front writes into the queue in one cycle
  typedef struct packed {
    logic [1:0] n;
    run_cmd_t   cmd0;
    run_cmd_t   cmd1;
  } push_t;

endpackage

`default_nettype wire

### design/rle_front.sv
// front end: takes input bytes, tracks the current run and issues finished runs
// depends on rle_pkg
`default_nettype none

module rle_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // in_byte
  input  wire logic          s_tlast,   // stream_end
  input  wire logic          room,
  output rle_pkg::push_t     push
);

  logic [7:0] held_byte;
  logic       have_byte;
  logic [3:0] repeat_count;

  logic [7:0] held_byte_next;
  logic       have_byte_next;
  logic [3:0] repeat_count_next;
  logic       accept;
  logic       run_end;

  assign s_tready = room;
  assign accept   = s_tvalid & s_tready;

  // run tracking and queue writes
  always_comb begin
    held_byte_next    = held_byte;
    have_byte_next    = have_byte;
    repeat_count_next = repeat_count;
    run_end           = 1'b0;
    push              = '0;
    if (accept) begin
      if (!have_byte) begin
        held_byte_next    = s_tdata;
        have_byte_next    = 1'b1;
        repeat_count_next = 4'd0;
      end else if (s_tdata == held_byte && repeat_count < 4'(rle_pkg::MAX_EXTRA)) begin
        repeat_count_next = repeat_count + 4'd1;
      end else begin
        run_end           = 1'b1;
        held_byte_next    = s_tdata;
        repeat_count_next = 4'd0;
      end
      // old run first, then the flush of the new one
      if (run_end) begin
        push.cmd0.run_byte = held_byte;
        push.cmd0.extra    = repeat_count;
        push.cmd0.last     = ~s_tlast;
        push.cmd1.run_byte = held_byte_next;
        push.cmd1.extra    = repeat_count_next;
        push.cmd1.last     = 1'b1;
      end else begin
        push.cmd0.run_byte = held_byte_next;
        push.cmd0.extra    = repeat_count_next;
        push.cmd0.last     = 1'b1;
      end
      push.n = 2'(run_end) + 2'(s_tlast);
      if (s_tlast) begin
        have_byte_next    = 1'b0;
        repeat_count_next = 4'd0;
      end
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte    <= '0;
      have_byte    <= 1'b0;
      repeat_count <= '0;
    end else begin
      held_byte    <= held_byte_next;
      have_byte    <= have_byte_next;
      repeat_count <= repeat_count_next;
    end
  end

endmodule

`default_nettype wire

### design/rle_queue.sv
// short run queue between front and back; takes up to two runs a cycle
// depends on rle_pkg
`default_nettype none

module rle_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rle_pkg::push_t    push,
  input  wire logic              pop,
  output rle_pkg::run_cmd_t      head,
  output logic                   head_valid,
  output logic                   room
);

  rle_pkg::run_cmd_t                entries [rle_pkg::QUEUE_DEPTH];
  logic [rle_pkg::PTR_W-1:0]        wr_ptr;
  logic [rle_pkg::PTR_W-1:0]        rd_ptr;
  logic [rle_pkg::CNT_W-1:0]        count;
  logic [rle_pkg::PTR_W-1:0]        wr_ptr_b;

  assign wr_ptr_b   = wr_ptr + rle_pkg::PTR_W'(1);
  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  // space for the worst case of two runs from one transfer
  assign room = (count <= rle_pkg::CNT_W'(rle_pkg::QUEUE_DEPTH - 2));

  // storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr_ptr] <= push.cmd0;
    end
    if (push.n == 2'd2) begin
      entries[wr_ptr_b] <= push.cmd1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + rle_pkg::PTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + rle_pkg::PTR_W'(1);
      end
      count <= count + rle_pkg::CNT_W'(push.n) - rle_pkg::CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= rle_pkg::CNT_W'(rle_pkg::QUEUE_DEPTH))
    else $error("run queue overfilled");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("run queue popped while empty");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> room)
    else $error("run written without room");

  a_level_tracks: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + rle_pkg::CNT_W'($past(push.n))
                   - rle_pkg::CNT_W'($past(pop)))
    else $error("run queue level out of step");
`endif

endmodule

`default_nettype wire

### design/rle_back.sv
// back end: expands queued runs into literal, marker and digit bytes
// depends on rle_pkg
`default_nettype none

module rle_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rle_pkg::run_cmd_t head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,   // out_byte
  output logic                   m_tlast    // last_out
);

  logic [1:0] phase;
  logic [1:0] last_phase;
  logic       load;
  logic       final_byte;
  logic [7:0] byte_sel;

  // byte count of the run minus one
  always_comb begin
    if (head.extra >= rle_pkg::MARKER_MIN) begin
      last_phase = 2'd2;
    end else if (head.extra == 4'd1) begin
      last_phase = 2'd1;
    end else begin
      last_phase = 2'd0;
    end
  end

  // pick the byte for this phase
  always_comb begin
    byte_sel = head.run_byte;
    if (head.extra >= rle_pkg::MARKER_MIN) begin
      if (phase == 2'd1) begin
        byte_sel = rle_pkg::MARKER_BYTE;
      end else if (phase == 2'd2) begin
        byte_sel = rle_pkg::DIGIT_ZERO + {4'd0, head.extra};
      end
    end
  end

  assign load       = head_valid & (~m_tvalid | m_tready);
  assign final_byte = (phase == last_phase);
  assign pop        = load & final_byte;

  // output register and phase counter
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        phase    <= final_byte ? 2'd0 : phase + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_sel;
      m_tlast <= final_byte & head.last;
    end
  end

endmodule

`default_nettype wire

### design/run_length_encoder_marker_core.sv
// run-length encoder with '$' count marker: input reaches the output through a run
// queue entry and the back end output register; one input byte per cycle is taken
// while the run queue has room for two runs; the back end expands each run into 1
// to 3 bytes, one per cycle while m_tready is high. synchronous active-high reset
// empties the queue and clears the held run; no clearing pass is needed
// depends on rle_pkg, rle_front, rle_queue, rle_back
`default_nettype none

module run_length_encoder_marker_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // in_byte
  input  wire logic       s_tlast,   // stream_end
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // out_byte
  output logic            m_tlast    // last_out
);

  rle_pkg::push_t    push;
  rle_pkg::run_cmd_t head;
  logic              head_valid;
  logic              pop;
  logic              room;

  rle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .room     (room),
    .push     (push)
  );

  rle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  rle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire
